FILE: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Bodies compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop)
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/ffha_pkg.sv
// Shared constants, codes and cell interface structs of the allocator.
// No dependencies.
package ffha_pkg;
  localparam int SEG_N         = 32;
  localparam int USED_N        = 32;
  localparam int LINK_BYTES    = 8;
  localparam int SPLIT_HEADERS = 2;
  localparam int SH_MIN        = 2;
  localparam int SH_MAX        = 12;
  localparam int SEG_IDX_W     = $clog2(SEG_N);
  localparam int SEG_CNT_W     = $clog2(SEG_N + 1);
  localparam int USED_IDX_W    = $clog2(USED_N);
  localparam int MASK_W        = SH_MAX;
  localparam int HDR_W         = SH_MAX + 1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0, REQ_FREE = 2'd1, REQ_INIT = 2'd2, REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOMEM = 2'd1, ST_NOTALLOC = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_ALIGN = 3'd0, CFG_R0_BASE = 3'd1, CFG_R0_SIZE = 3'd2,
    CFG_R1_BASE = 3'd3, CFG_R1_SIZE = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_NOP = 2'd0, SEG_WRITE = 2'd1, SEG_INSERT = 2'd2, SEG_DELETE = 2'd3
  } seg_op_t;

  typedef enum logic [1:0] {
    U_NOP = 2'd0, U_WRITE = 2'd1, U_CLEAR = 2'd2, U_CLEAR_ALL = 2'd3
  } used_op_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } seg_ent_t;

  typedef struct packed {
    seg_op_t               op;
    logic [SEG_IDX_W-1:0]  pos;
    seg_ent_t              ent;
  } seg_cmd_t;

  // mode 0: first entry with len >= key; mode 1: first entry with start > key
  typedef struct packed {
    logic                  v;
    logic                  mode;
    logic [31:0]           key;
    logic                  found;
    logic [SEG_IDX_W-1:0]  f_idx;
    seg_ent_t              f_ent;
    logic                  last_v;
    logic [SEG_IDX_W-1:0]  last_idx;
    seg_ent_t              last_ent;
  } seg_tok_t;

  typedef struct packed {
    used_op_t              op;
    logic [USED_IDX_W-1:0] pos;
    seg_ent_t              ent;
  } used_cmd_t;

  // mode 0: first empty slot; mode 1: valid slot with start + header == key
  typedef struct packed {
    logic                  v;
    logic                  mode;
    logic [31:0]           key;
    logic                  found;
    logic [USED_IDX_W-1:0] idx;
    seg_ent_t              ent;
  } used_tok_t;
endpackage

FILE: sv/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: request sequencer, config
// registers, and the segment and allocated-block cell chains.
// Depends on ffha_pkg, ffha_seg_cell, ffha_used_cell, assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | req_type, req_size, free_addr
//  out_    | output    | out_valid / out_ready | status, user_addr, block_bytes,
//          |           |                       | free_bytes, min_free_bytes
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time. Allocate makes one token pass down both cell chains;
// free makes a block lookup, then a position search; init steps through
// states S_INIT1 to S_INIT6. Search time grows with the chain length.
// Reset is synchronous, active low; no clearing pass is needed.
// A result waiting on out_ready holds only the sequencer's final state, S_DONE.
`include "assert_macros.svh"
module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_user_addr,
  output logic [31:0] out_block_bytes,
  output logic [31:0] out_free_bytes,
  output logic [31:0] out_min_free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ACHK, S_ASRCH, S_AUPD, S_FUSRCH, S_FSSRCH, S_FUPD, S_FUPD2,
    S_INIT1, S_INIT2, S_INIT3, S_INIT4, S_INIT5, S_INIT6, S_DONE
  } state_t;

  state_t state_r;

  logic [3:0]  cfg_align_r;
  logic [31:0] cfg_r0_base_r, cfg_r0_size_r, cfg_r1_base_r, cfg_r1_size_r;

  logic [1:0]  req_type_r;
  logic [31:0] req_size_r, free_addr_r;

  logic [3:0]        sh_r;
  logic [MASK_W-1:0] mask_r;
  logic [HDR_W-1:0]  hdr_r;
  logic              ready_r;
  logic [SEG_CNT_W-1:0] seg_count_r;
  logic [31:0]       free_total_r, free_low_r;
  logic [32:0]       want_r;

  seg_tok_t  sres_r;
  used_tok_t ures_r;
  logic      seg_got_r, used_got_r;

  logic [32:0] a0_r, a1_r, top0_r, top1_r, e0_r, e1_r;
  logic        ok0_r, ok1_r, u0, u1;

  status_t     res_status_r;
  logic [31:0] res_uaddr_r, res_blen_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_uaddr_r, out_blen_r, out_free_r, out_low_r;

  // chains
  seg_ent_t  seg_ent [SEG_N];
  seg_tok_t  seg_tok [SEG_N+1];
  used_tok_t used_tok [USED_N+1];
  seg_cmd_t  seg_cmd;
  used_cmd_t used_cmd;
  seg_tok_t  seg_end;
  used_tok_t used_end;

  assign seg_end  = seg_tok[SEG_N];
  assign used_end = used_tok[USED_N];

  for (genvar j = 0; j < SEG_N; j++) begin : g_seg
    seg_ent_t up_ent, dn_ent;
    if (j == 0) begin : g_first
      assign up_ent = seg_cmd.ent;
    end else begin : g_up
      assign up_ent = seg_ent[j-1];
    end
    if (j == SEG_N - 1) begin : g_last
      assign dn_ent = seg_ent[j];
    end else begin : g_dn
      assign dn_ent = seg_ent[j+1];
    end
    ffha_seg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SEG_IDX_W'(j)),
      .seg_count(seg_count_r),
      .cmd      (seg_cmd),
      .up_ent   (up_ent),
      .dn_ent   (dn_ent),
      .tok_in   (seg_tok[j]),
      .tok_out  (seg_tok[j+1]),
      .ent_out  (seg_ent[j])
    );
  end

  for (genvar j = 0; j < USED_N; j++) begin : g_used
    ffha_used_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(USED_IDX_W'(j)),
      .hdr     (hdr_r),
      .cmd     (used_cmd),
      .tok_in  (used_tok[j]),
      .tok_out (used_tok[j+1])
    );
  end

  // alignment from the config register
  logic [3:0]        sh_c;
  logic [MASK_W-1:0] mask_c;
  logic [HDR_W-1:0]  hdr_c;
  logic [32:0]       mask33;

  always_comb begin
    if (cfg_align_r < 4'(SH_MIN)) sh_c = 4'(SH_MIN);
    else if (cfg_align_r > 4'(SH_MAX)) sh_c = 4'(SH_MAX);
    else sh_c = cfg_align_r;
    mask_c = MASK_W'(((MASK_W+1)'(1) << sh_c) - (MASK_W+1)'(1));
    hdr_c  = (HDR_W'(LINK_BYTES) + HDR_W'(mask_c)) & ~HDR_W'(mask_c);
  end

  assign mask33 = 33'(mask_r);

  // allocate checks and split decision
  logic        a_fail;
  logic [31:0] a_rem, a_blk;
  logic        a_split;
  status_t     a_status;

  assign a_fail   = !ready_r || (req_size_r == 32'd0) || req_size_r[31] ||
                    (want_r > {1'b0, free_total_r});
  assign a_rem    = sres_r.f_ent.len - want_r[31:0];
  assign a_split  = a_rem > (32'(hdr_r) * 32'(SPLIT_HEADERS));
  assign a_blk    = a_split ? want_r[31:0] : sres_r.f_ent.len;
  assign a_status = !sres_r.found ? ST_NOMEM : (!ures_r.found ? ST_FULL : ST_OK);

  // free coalescing decision
  logic                 f_prev, f_next, f_full;
  logic [SEG_IDX_W-1:0] f_pos;

  assign f_prev = sres_r.last_v &&
                  ({1'b0, sres_r.last_ent.start} + {1'b0, sres_r.last_ent.len} ==
                   {1'b0, ures_r.ent.start});
  assign f_next = sres_r.found &&
                  ({1'b0, ures_r.ent.start} + {1'b0, ures_r.ent.len} ==
                   {1'b0, sres_r.f_ent.start});
  assign f_full = !f_prev && !f_next && (seg_count_r >= SEG_CNT_W'(SEG_N));
  assign f_pos  = sres_r.found ? sres_r.f_idx : seg_count_r[SEG_IDX_W-1:0];

  // init region results
  logic        use1, u0g;
  logic [31:0] len0, len1;

  assign u0   = ok0_r && (e0_r > a0_r);
  assign u1   = ok1_r && (e1_r > a1_r);
  assign u0g  = (cfg_r0_size_r != 32'd0) && u0;
  assign use1 = (cfg_r0_size_r != 32'd0) && (cfg_r1_size_r != 32'd0) && u1 &&
                (a1_r > (u0 ? e0_r : a0_r));
  assign len0 = 32'(e0_r - a0_r);
  assign len1 = 32'(e1_r - a1_r);

  // token launch and cell commands
  always_comb begin
    seg_tok[0]  = '0;
    used_tok[0] = '0;
    seg_cmd     = '0;
    used_cmd    = '0;
    unique case (state_r)
      S_PREP: begin
        if (req_type_r == REQ_FREE && free_addr_r != 32'd0) begin
          used_tok[0].v    = 1'b1;
          used_tok[0].mode = 1'b1;
          used_tok[0].key  = free_addr_r;
        end
      end
      S_ACHK: begin
        if (!a_fail) begin
          seg_tok[0].v    = 1'b1;
          seg_tok[0].key  = want_r[31:0];
          used_tok[0].v   = 1'b1;
        end
      end
      S_FUSRCH: begin
        if (used_end.v && used_end.found) begin
          seg_tok[0].v    = 1'b1;
          seg_tok[0].mode = 1'b1;
          seg_tok[0].key  = used_end.ent.start;
        end
      end
      S_AUPD: begin
        if (a_status == ST_OK) begin
          seg_cmd.pos = sres_r.f_idx;
          if (a_split) begin
            seg_cmd.op        = SEG_WRITE;
            seg_cmd.ent.start = sres_r.f_ent.start + want_r[31:0];
            seg_cmd.ent.len   = a_rem;
          end else begin
            seg_cmd.op = SEG_DELETE;
          end
          used_cmd.op        = U_WRITE;
          used_cmd.pos       = ures_r.idx;
          used_cmd.ent.start = sres_r.f_ent.start;
          used_cmd.ent.len   = a_blk;
        end
      end
      S_FUPD: begin
        if (!f_full) begin
          used_cmd.op  = U_CLEAR;
          used_cmd.pos = ures_r.idx;
          if (f_prev) begin
            seg_cmd.op        = SEG_WRITE;
            seg_cmd.pos       = sres_r.last_idx;
            seg_cmd.ent.start = sres_r.last_ent.start;
            seg_cmd.ent.len   = sres_r.last_ent.len + ures_r.ent.len +
                                (f_next ? sres_r.f_ent.len : 32'd0);
          end else if (f_next) begin
            seg_cmd.op        = SEG_WRITE;
            seg_cmd.pos       = f_pos;
            seg_cmd.ent.start = ures_r.ent.start;
            seg_cmd.ent.len   = sres_r.f_ent.len + ures_r.ent.len;
          end else begin
            seg_cmd.op  = SEG_INSERT;
            seg_cmd.pos = f_pos;
            seg_cmd.ent = ures_r.ent;
          end
        end
      end
      S_FUPD2: begin
        seg_cmd.op  = SEG_DELETE;
        seg_cmd.pos = sres_r.f_idx;
      end
      S_INIT5: begin
        used_cmd.op = U_CLEAR_ALL;
        if (u0g) begin
          seg_cmd.op        = SEG_WRITE;
          seg_cmd.ent.start = a0_r[31:0];
          seg_cmd.ent.len   = len0;
        end
      end
      S_INIT6: begin
        if (use1) begin
          seg_cmd.op        = SEG_WRITE;
          seg_cmd.pos       = u0g ? SEG_IDX_W'(1) : '0;
          seg_cmd.ent.start = a1_r[31:0];
          seg_cmd.ent.len   = len1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_align_r   <= 4'd3;
      cfg_r0_base_r <= '0;
      cfg_r0_size_r <= '0;
      cfg_r1_base_r <= '0;
      cfg_r1_size_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALIGN:   cfg_align_r   <= cfg_data[3:0];
        CFG_R0_BASE: cfg_r0_base_r <= cfg_data;
        CFG_R0_SIZE: cfg_r0_size_r <= cfg_data;
        CFG_R1_BASE: cfg_r1_base_r <= cfg_data;
        CFG_R1_SIZE: cfg_r1_size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_req_size;
      free_addr_r <= in_free_addr;
    end
    if (state_r == S_PREP)
      want_r <= ({1'b0, req_size_r} + 33'(hdr_r) + mask33) & ~mask33;
    if (seg_end.v) sres_r <= seg_end;
    if (used_end.v) ures_r <= used_end;
    if (state_r == S_INIT2) begin
      a0_r   <= ({1'b0, cfg_r0_base_r} + mask33) & ~mask33;
      a1_r   <= ({1'b0, cfg_r1_base_r} + mask33) & ~mask33;
      top0_r <= {1'b0, cfg_r0_base_r} + {1'b0, cfg_r0_size_r};
      top1_r <= {1'b0, cfg_r1_base_r} + {1'b0, cfg_r1_size_r};
    end
    if (state_r == S_INIT3) begin
      // clip the region end at the top of the address space
      if (top0_r[32] && top0_r[31:0] != 32'd0) top0_r <= {1'b1, 32'd0};
      if (top1_r[32] && top1_r[31:0] != 32'd0) top1_r <= {1'b1, 32'd0};
    end
    if (state_r == S_INIT4) begin
      ok0_r <= top0_r >= a0_r + 33'(hdr_r);
      ok1_r <= top1_r >= a1_r + 33'(hdr_r);
      e0_r  <= (top0_r - 33'(hdr_r)) & ~mask33;
      e1_r  <= (top1_r - 33'(hdr_r)) & ~mask33;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sh_r         <= 4'd3;
      mask_r       <= MASK_W'(7);
      hdr_r        <= HDR_W'(LINK_BYTES);
      ready_r      <= 1'b0;
      seg_count_r  <= '0;
      free_total_r <= '0;
      free_low_r   <= '0;
      seg_got_r    <= 1'b0;
      used_got_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_status_r <= ST_OK;
            res_uaddr_r  <= '0;
            res_blen_r   <= '0;
            seg_got_r    <= 1'b0;
            used_got_r   <= 1'b0;
            state_r      <= S_PREP;
          end
        end
        S_PREP: begin
          unique case (req_type_r)
            REQ_ALLOC: state_r <= S_ACHK;
            REQ_FREE:  state_r <= (free_addr_r == 32'd0) ? S_DONE : S_FUSRCH;
            REQ_INIT:  state_r <= S_INIT1;
            default:   state_r <= S_DONE;
          endcase
        end
        S_ACHK: begin
          if (a_fail) begin
            res_status_r <= ST_NOMEM;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_ASRCH;
          end
        end
        S_ASRCH: begin
          if (seg_end.v) seg_got_r <= 1'b1;
          if (used_end.v) used_got_r <= 1'b1;
          if ((seg_got_r || seg_end.v) && (used_got_r || used_end.v)) state_r <= S_AUPD;
        end
        S_AUPD: begin
          res_status_r <= a_status;
          if (a_status == ST_OK) begin
            if (!a_split) seg_count_r <= seg_count_r - SEG_CNT_W'(1);
            free_total_r <= free_total_r - a_blk;
            if (free_total_r - a_blk < free_low_r) free_low_r <= free_total_r - a_blk;
            res_uaddr_r  <= sres_r.f_ent.start + 32'(hdr_r);
            res_blen_r   <= a_blk;
          end
          state_r <= S_DONE;
        end
        S_FUSRCH: begin
          if (used_end.v) begin
            if (used_end.found) begin
              state_r <= S_FSSRCH;
            end else begin
              res_status_r <= ST_NOTALLOC;
              state_r      <= S_DONE;
            end
          end
        end
        S_FSSRCH: begin
          if (seg_end.v) state_r <= S_FUPD;
        end
        S_FUPD: begin
          if (f_full) begin
            res_status_r <= ST_FULL;
            state_r      <= S_DONE;
          end else begin
            free_total_r <= free_total_r + ures_r.ent.len;
            res_blen_r   <= ures_r.ent.len;
            if (f_prev && f_next) begin
              seg_count_r <= seg_count_r - SEG_CNT_W'(1);
              state_r     <= S_FUPD2;
            end else begin
              if (!f_prev && !f_next) seg_count_r <= seg_count_r + SEG_CNT_W'(1);
              state_r <= S_DONE;
            end
          end
        end
        S_FUPD2: state_r <= S_DONE;
        S_INIT1: begin
          sh_r    <= sh_c;
          mask_r  <= mask_c;
          hdr_r   <= hdr_c;
          state_r <= S_INIT2;
        end
        S_INIT2: state_r <= S_INIT3;
        S_INIT3: state_r <= S_INIT4;
        S_INIT4: state_r <= S_INIT5;
        S_INIT5: state_r <= S_INIT6;
        S_INIT6: begin
          seg_count_r  <= SEG_CNT_W'({1'b0, u0g} + {1'b0, use1});
          free_total_r <= (u0g ? len0 : 32'd0) + (use1 ? len1 : 32'd0);
          free_low_r   <= (u0g ? len0 : 32'd0) + (use1 ? len1 : 32'd0);
          ready_r      <= 1'b1;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_uaddr_r  <= res_uaddr_r;
            out_blen_r   <= res_blen_r;
            out_free_r   <= free_total_r;
            out_low_r    <= free_low_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_user_addr      = out_uaddr_r;
  assign out_block_bytes    = out_blen_r;
  assign out_free_bytes     = out_free_r;
  assign out_min_free_bytes = out_low_r;

  // shift kept for visibility of the latched alignment
  logic sh_in_range;
  assign sh_in_range = (sh_r >= 4'(SH_MIN)) && (sh_r <= 4'(SH_MAX));

  `FFHA_ASSERT(a_seg_count_max, clk, rst_n, seg_count_r <= SEG_CNT_W'(SEG_N))
  `FFHA_ASSERT(a_low_mark, clk, rst_n, free_low_r <= free_total_r)
  `FFHA_ASSERT(a_seg_tok_state, clk, rst_n,
               seg_end.v |-> (state_r == S_ASRCH || state_r == S_FSSRCH))
  `FFHA_ASSERT(a_accept_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `FFHA_ASSERT(a_shift_range, clk, rst_n, sh_in_range)
endmodule

FILE: sv/ffha_seg_cell.sv
// One cell of the sorted free-segment chain: holds one segment entry,
// shifts with its neighbors on insert/delete and forwards the search token.
// Depends on ffha_pkg.
module ffha_seg_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ffha_pkg::SEG_IDX_W-1:0] cell_idx,
  input  logic [ffha_pkg::SEG_CNT_W-1:0] seg_count,
  input  ffha_pkg::seg_cmd_t             cmd,
  input  ffha_pkg::seg_ent_t             up_ent,
  input  ffha_pkg::seg_ent_t             dn_ent,
  input  ffha_pkg::seg_tok_t             tok_in,
  output ffha_pkg::seg_tok_t             tok_out,
  output ffha_pkg::seg_ent_t             ent_out
);
  import ffha_pkg::*;

  seg_ent_t ent_r;
  seg_tok_t tok_r, tok_nxt;
  logic     live, hit;

  assign live = {1'b0, cell_idx} < seg_count;
  assign hit  = tok_in.mode ? (ent_r.start > tok_in.key) : (ent_r.len >= tok_in.key);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.v && !tok_in.found && live) begin
      if (hit) begin
        tok_nxt.found = 1'b1;
        tok_nxt.f_idx = cell_idx;
        tok_nxt.f_ent = ent_r;
      end else begin
        tok_nxt.last_v   = 1'b1;
        tok_nxt.last_idx = cell_idx;
        tok_nxt.last_ent = ent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      SEG_WRITE: begin
        if (cell_idx == cmd.pos) ent_r <= cmd.ent;
      end
      SEG_INSERT: begin
        if (cell_idx == cmd.pos) ent_r <= cmd.ent;
        else if (cell_idx > cmd.pos) ent_r <= up_ent;
      end
      SEG_DELETE: begin
        if (cell_idx >= cmd.pos) ent_r <= dn_ent;
      end
      default: begin
      end
    endcase
  end

  assign tok_out = tok_r;
  assign ent_out = ent_r;
endmodule

FILE: sv/ffha_used_cell.sv
// One cell of the allocated-block chain: holds one block record with its
// valid bit and forwards the slot/match search token.
// Depends on ffha_pkg.
module ffha_used_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ffha_pkg::USED_IDX_W-1:0] cell_idx,
  input  logic [ffha_pkg::HDR_W-1:0]      hdr,
  input  ffha_pkg::used_cmd_t             cmd,
  input  ffha_pkg::used_tok_t             tok_in,
  output ffha_pkg::used_tok_t             tok_out
);
  import ffha_pkg::*;

  seg_ent_t  ent_r;
  logic      valid_r;
  used_tok_t tok_r, tok_nxt;
  logic      hit;

  assign hit = tok_in.mode ? (valid_r && (ent_r.start + 32'(hdr) == tok_in.key)) : !valid_r;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.v && !tok_in.found && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = cell_idx;
      tok_nxt.ent   = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      unique case (cmd.op)
        U_WRITE:     if (cell_idx == cmd.pos) valid_r <= 1'b1;
        U_CLEAR:     if (cell_idx == cmd.pos) valid_r <= 1'b0;
        U_CLEAR_ALL: valid_r <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == U_WRITE && cell_idx == cmd.pos) ent_r <= cmd.ent;
  end

  assign tok_out = tok_r;
endmodule
